### rtl/core/mbrot_pkg.sv
package mbrot_pkg;

    localparam int COORD_BITS   = 12;
    localparam int ITER_BITS    = 16;
    localparam int VAL_BITS     = 64;
    localparam int HALF_BITS    = VAL_BITS / 2;
    localparam int ACC_BITS     = 2 * VAL_BITS;
    localparam int FRAC_BITS    = 60;
    localparam int CROSS_SHIFT  = FRAC_BITS - 1;
    localparam int CFG_IDX_BITS = 3;
    localparam int PART_BITS    = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_REAL_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REAL_STEP   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAG_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAG_STEP   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ITER_LIMIT  = 3'd4;

    localparam logic [ITER_BITS-1:0] ITER_LIMIT_RESET = ITER_BITS'(500);

    // escape bounds, +2 and -2 in Q3.60
    localparam logic signed [VAL_BITS-1:0] ESC_POS = 64'sh2000_0000_0000_0000;
    localparam logic signed [VAL_BITS-1:0] ESC_NEG = -64'sh2000_0000_0000_0000;

    // partial product steps of one 64 x 64 job: a half x b half
    localparam logic [PART_BITS-1:0] PART_LL    = 3'd0;
    localparam logic [PART_BITS-1:0] PART_LH    = 3'd1;
    localparam logic [PART_BITS-1:0] PART_HL    = 3'd2;
    localparam logic [PART_BITS-1:0] PART_HH    = 3'd3;
    localparam logic [PART_BITS-1:0] PART_DRAIN = 3'd4;
    localparam logic [PART_BITS-1:0] PART_FINAL = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_ADD,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        JOB_MAP_RE,
        JOB_MAP_IM,
        JOB_SQ_RE,
        JOB_SQ_IM,
        JOB_CROSS
    } job_t;

endpackage

### rtl/core/mandelbrot_escape_time.sv
// channel   | direction | handshake              | beat
// ----------+-----------+------------------------+------------------------------
// pixel in  | in        | in_valid / in_ready    | pixel_x, pixel_y
// result    | out       | out_valid / out_ready  | iter_count, inside_res
// config    | in        | cfg_we (no wait)       | cfg_index, cfg_data
//
// each pixel runs on the single 32x32 multiplier: four partial products per 64-bit
// product, two products to map the pixel, three products per iteration done (at most
// the iteration limit)
// reset clears the sequencer and the result valid flag and loads the register reset values
// in_ready is high only while idle; a finished result sits in the output register,
// so the next pixel is taken while it waits, and the core holds at its end until free
module mandelbrot_escape_time (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mbrot_pkg::COORD_BITS-1:0]    pixel_x,
    input  logic [mbrot_pkg::COORD_BITS-1:0]    pixel_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mbrot_pkg::ITER_BITS-1:0]     iter_count,
    output logic                                inside_res,
    input  logic                                cfg_we,
    input  logic [mbrot_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [mbrot_pkg::VAL_BITS-1:0]      cfg_data
);

    mbrot_pkg::state_t state_reg;
    mbrot_pkg::state_t state_next;
    mbrot_pkg::job_t   job_reg;
    mbrot_pkg::job_t   job_next;
    logic [mbrot_pkg::PART_BITS-1:0] part_reg;
    logic [mbrot_pkg::PART_BITS-1:0] part_next;

    logic signed [mbrot_pkg::VAL_BITS-1:0] real_origin_reg;
    logic signed [mbrot_pkg::VAL_BITS-1:0] real_step_reg;
    logic signed [mbrot_pkg::VAL_BITS-1:0] imag_origin_reg;
    logic signed [mbrot_pkg::VAL_BITS-1:0] imag_step_reg;
    logic [mbrot_pkg::ITER_BITS-1:0]       iter_limit_reg;

    logic [mbrot_pkg::COORD_BITS-1:0] px_reg;
    logic [mbrot_pkg::COORD_BITS-1:0] py_reg;

    logic signed [mbrot_pkg::VAL_BITS-1:0] c_re_reg;
    logic signed [mbrot_pkg::VAL_BITS-1:0] c_im_reg;
    logic signed [mbrot_pkg::VAL_BITS-1:0] z_re_reg;
    logic signed [mbrot_pkg::VAL_BITS-1:0] z_im_reg;
    logic signed [mbrot_pkg::VAL_BITS-1:0] sq_re_reg;
    logic signed [mbrot_pkg::VAL_BITS-1:0] sq_im_reg;
    logic signed [mbrot_pkg::VAL_BITS-1:0] cross_reg;
    logic [mbrot_pkg::VAL_BITS-1:0]        mag_re_reg;
    logic [mbrot_pkg::VAL_BITS-1:0]        mag_im_reg;
    logic                                  neg_cross_reg;

    logic [mbrot_pkg::VAL_BITS-1:0] prod_reg;
    logic [1:0]                     prod_part_reg;
    logic [mbrot_pkg::ACC_BITS-1:0] acc_reg;

    logic [mbrot_pkg::ITER_BITS-1:0] count_reg;
    logic                            escaped_reg;

    logic [mbrot_pkg::ITER_BITS-1:0] iter_count_reg;
    logic                            inside_reg;
    logic                            out_valid_reg;

    // control decode
    logic start;
    logic stop;
    logic load_out;
    logic do_issue;
    logic do_clear;
    logic do_acc;
    logic do_final;
    logic do_prep;
    logic do_add;

    // shared multiplier and accumulator
    logic [mbrot_pkg::VAL_BITS-1:0]  op_a;
    logic [mbrot_pkg::VAL_BITS-1:0]  op_b;
    logic [mbrot_pkg::HALF_BITS-1:0] mul_a;
    logic [mbrot_pkg::HALF_BITS-1:0] mul_b;
    logic [mbrot_pkg::VAL_BITS-1:0]  mul_p;
    logic [mbrot_pkg::ACC_BITS-1:0]  acc_term;
    logic [mbrot_pkg::ACC_BITS-1:0]  acc_init;

    // rounding of the finished product
    logic [mbrot_pkg::VAL_BITS-1:0] fin_mag;
    logic                           fin_rem;
    logic                           fin_neg;
    logic [mbrot_pkg::VAL_BITS-1:0] fin_val;

    // update of z
    logic signed [mbrot_pkg::VAL_BITS-1:0] diff_re;
    logic signed [mbrot_pkg::VAL_BITS:0]   sum_re;
    logic signed [mbrot_pkg::VAL_BITS:0]   sum_im;
    logic signed [mbrot_pkg::VAL_BITS-1:0] new_re;
    logic signed [mbrot_pkg::VAL_BITS-1:0] new_im;
    logic                                  esc_re;
    logic                                  esc_im;

    assign stop = escaped_reg || (count_reg >= iter_limit_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        part_next  = part_reg;
        unique case (state_reg)
            mbrot_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mbrot_pkg::ST_MUL;
                    job_next   = mbrot_pkg::JOB_MAP_RE;
                    part_next  = mbrot_pkg::PART_LL;
                end
            end
            mbrot_pkg::ST_MUL:
            begin
                if (part_reg == mbrot_pkg::PART_FINAL)
                begin
                    part_next = mbrot_pkg::PART_LL;
                    unique case (job_reg)
                        mbrot_pkg::JOB_MAP_RE: job_next = mbrot_pkg::JOB_MAP_IM;
                        mbrot_pkg::JOB_MAP_IM: state_next = mbrot_pkg::ST_PREP;
                        mbrot_pkg::JOB_SQ_RE:  job_next = mbrot_pkg::JOB_SQ_IM;
                        mbrot_pkg::JOB_SQ_IM:  job_next = mbrot_pkg::JOB_CROSS;
                        mbrot_pkg::JOB_CROSS:  state_next = mbrot_pkg::ST_ADD;
                        default:               state_next = mbrot_pkg::ST_IDLE;
                    endcase
                end
                else
                begin
                    part_next = part_reg + 3'd1;
                end
            end
            mbrot_pkg::ST_PREP:
            begin
                if (stop)
                begin
                    state_next = mbrot_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = mbrot_pkg::ST_MUL;
                    job_next   = mbrot_pkg::JOB_SQ_RE;
                    part_next  = mbrot_pkg::PART_LL;
                end
            end
            mbrot_pkg::ST_ADD:
            begin
                state_next = mbrot_pkg::ST_PREP;
            end
            mbrot_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = mbrot_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mbrot_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready = 1'b0;
        load_out = 1'b0;
        do_issue = 1'b0;
        do_clear = 1'b0;
        do_acc   = 1'b0;
        do_final = 1'b0;
        do_prep  = 1'b0;
        do_add   = 1'b0;
        unique case (state_reg)
            mbrot_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            mbrot_pkg::ST_MUL:
            begin
                do_issue = (part_reg <= mbrot_pkg::PART_HH);
                do_clear = (part_reg == mbrot_pkg::PART_LL);
                do_acc   = (part_reg >= mbrot_pkg::PART_LH)
                        && (part_reg <= mbrot_pkg::PART_DRAIN);
                do_final = (part_reg == mbrot_pkg::PART_FINAL);
            end
            mbrot_pkg::ST_PREP:
            begin
                do_prep = !stop;
            end
            mbrot_pkg::ST_ADD:
            begin
                do_add = 1'b1;
            end
            mbrot_pkg::ST_FINISH:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign start = in_valid && in_ready;

    // operand selection for the current job
    always_comb
    begin
        unique case (job_reg)
            mbrot_pkg::JOB_MAP_RE:
            begin
                op_a     = mbrot_pkg::VAL_BITS'(px_reg);
                op_b     = real_step_reg;
                acc_init = mbrot_pkg::ACC_BITS'(unsigned'(real_origin_reg));
            end
            mbrot_pkg::JOB_MAP_IM:
            begin
                op_a     = mbrot_pkg::VAL_BITS'(py_reg);
                op_b     = imag_step_reg;
                acc_init = mbrot_pkg::ACC_BITS'(unsigned'(imag_origin_reg));
            end
            mbrot_pkg::JOB_SQ_RE:
            begin
                op_a     = mag_re_reg;
                op_b     = mag_re_reg;
                acc_init = '0;
            end
            mbrot_pkg::JOB_SQ_IM:
            begin
                op_a     = mag_im_reg;
                op_b     = mag_im_reg;
                acc_init = '0;
            end
            mbrot_pkg::JOB_CROSS:
            begin
                op_a     = mag_re_reg;
                op_b     = mag_im_reg;
                acc_init = '0;
            end
            default:
            begin
                op_a     = '0;
                op_b     = '0;
                acc_init = '0;
            end
        endcase
    end

    assign mul_a = part_reg[1] ? op_a[mbrot_pkg::VAL_BITS-1:mbrot_pkg::HALF_BITS]
                               : op_a[mbrot_pkg::HALF_BITS-1:0];
    assign mul_b = part_reg[0] ? op_b[mbrot_pkg::VAL_BITS-1:mbrot_pkg::HALF_BITS]
                               : op_b[mbrot_pkg::HALF_BITS-1:0];
    assign mul_p = mul_a * mul_b;

    // weight of the registered partial product
    always_comb
    begin
        unique case (prod_part_reg)
            2'b00:   acc_term = mbrot_pkg::ACC_BITS'(prod_reg);
            2'b11:   acc_term = mbrot_pkg::ACC_BITS'(prod_reg) << mbrot_pkg::VAL_BITS;
            default: acc_term = mbrot_pkg::ACC_BITS'(prod_reg) << mbrot_pkg::HALF_BITS;
        endcase
    end

    // floor of the signed product: -(q + r) = ~q + !r
    always_comb
    begin
        if (job_reg == mbrot_pkg::JOB_CROSS)
        begin
            fin_mag = acc_reg[mbrot_pkg::CROSS_SHIFT +: mbrot_pkg::VAL_BITS];
            fin_rem = |acc_reg[mbrot_pkg::CROSS_SHIFT-1:0];
            fin_neg = neg_cross_reg;
        end
        else
        begin
            fin_mag = acc_reg[mbrot_pkg::FRAC_BITS +: mbrot_pkg::VAL_BITS];
            fin_rem = |acc_reg[mbrot_pkg::FRAC_BITS-1:0];
            fin_neg = 1'b0;
        end
        fin_val = fin_neg ? (~fin_mag + mbrot_pkg::VAL_BITS'(!fin_rem)) : fin_mag;
    end

    assign diff_re = sq_re_reg - sq_im_reg;
    assign sum_re  = {diff_re[mbrot_pkg::VAL_BITS-1], diff_re}
                   + {c_re_reg[mbrot_pkg::VAL_BITS-1], c_re_reg};
    assign sum_im  = {cross_reg[mbrot_pkg::VAL_BITS-1], cross_reg}
                   + {c_im_reg[mbrot_pkg::VAL_BITS-1], c_im_reg};
    assign new_re  = sum_re[mbrot_pkg::VAL_BITS-1:0];
    assign new_im  = sum_im[mbrot_pkg::VAL_BITS-1:0];
    // a sum that leaves 64 bits is far outside the escape radius
    assign esc_re  = (sum_re[mbrot_pkg::VAL_BITS] != sum_re[mbrot_pkg::VAL_BITS-1])
                  || (new_re >= mbrot_pkg::ESC_POS) || (new_re <= mbrot_pkg::ESC_NEG);
    assign esc_im  = (sum_im[mbrot_pkg::VAL_BITS] != sum_im[mbrot_pkg::VAL_BITS-1])
                  || (new_im >= mbrot_pkg::ESC_POS) || (new_im <= mbrot_pkg::ESC_NEG);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbrot_pkg::ST_IDLE;
            job_reg       <= mbrot_pkg::JOB_MAP_RE;
            part_reg      <= mbrot_pkg::PART_LL;
            count_reg     <= '0;
            escaped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            part_reg  <= part_next;
            if (start)
            begin
                count_reg   <= '0;
                escaped_reg <= 1'b0;
            end
            else if (do_add)
            begin
                count_reg   <= count_reg + mbrot_pkg::ITER_BITS'(1);
                escaped_reg <= esc_re || esc_im;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_origin_reg <= '0;
            real_step_reg   <= '0;
            imag_origin_reg <= '0;
            imag_step_reg   <= '0;
            iter_limit_reg  <= mbrot_pkg::ITER_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbrot_pkg::CFG_REAL_ORIGIN: real_origin_reg <= cfg_data;
                mbrot_pkg::CFG_REAL_STEP:   real_step_reg   <= cfg_data;
                mbrot_pkg::CFG_IMAG_ORIGIN: imag_origin_reg <= cfg_data;
                mbrot_pkg::CFG_IMAG_STEP:   imag_step_reg   <= cfg_data;
                mbrot_pkg::CFG_ITER_LIMIT:
                    iter_limit_reg <= cfg_data[mbrot_pkg::ITER_BITS-1:0];
                default:
                    iter_limit_reg <= iter_limit_reg;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            px_reg   <= pixel_x;
            py_reg   <= pixel_y;
            z_re_reg <= '0;
            z_im_reg <= '0;
        end
        if (do_issue)
        begin
            prod_reg      <= mul_p;
            prod_part_reg <= part_reg[1:0];
        end
        if (do_clear)
        begin
            acc_reg <= acc_init;
        end
        else if (do_acc)
        begin
            acc_reg <= acc_reg + acc_term;
        end
        if (do_final)
        begin
            unique case (job_reg)
                mbrot_pkg::JOB_MAP_RE: c_re_reg  <= acc_reg[mbrot_pkg::VAL_BITS-1:0];
                mbrot_pkg::JOB_MAP_IM: c_im_reg  <= acc_reg[mbrot_pkg::VAL_BITS-1:0];
                mbrot_pkg::JOB_SQ_RE:  sq_re_reg <= fin_val;
                mbrot_pkg::JOB_SQ_IM:  sq_im_reg <= fin_val;
                mbrot_pkg::JOB_CROSS:  cross_reg <= fin_val;
                default:               cross_reg <= cross_reg;
            endcase
        end
        if (do_prep)
        begin
            mag_re_reg    <= z_re_reg[mbrot_pkg::VAL_BITS-1] ? unsigned'(-z_re_reg)
                                                             : unsigned'(z_re_reg);
            mag_im_reg    <= z_im_reg[mbrot_pkg::VAL_BITS-1] ? unsigned'(-z_im_reg)
                                                             : unsigned'(z_im_reg);
            neg_cross_reg <= z_re_reg[mbrot_pkg::VAL_BITS-1] ^ z_im_reg[mbrot_pkg::VAL_BITS-1];
        end
        if (do_add)
        begin
            z_re_reg <= new_re;
            z_im_reg <= new_im;
        end
        if (load_out)
        begin
            iter_count_reg <= count_reg;
            inside_reg     <= !escaped_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign iter_count = iter_count_reg;
    assign inside_res = inside_reg;

`ifndef ASSERT_OFF
    a_start_map: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == mbrot_pkg::ST_MUL)
            && (job_reg == mbrot_pkg::JOB_MAP_RE) && (part_reg == mbrot_pkg::PART_LL))
        else $error("pixel beat did not start the mapping job");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == mbrot_pkg::ST_FINISH))
        else $error("result shown without a finished pixel");

    a_add_after_cross: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbrot_pkg::ST_ADD) |-> $past((state_reg == mbrot_pkg::ST_MUL)
            && (job_reg == mbrot_pkg::JOB_CROSS) && (part_reg == mbrot_pkg::PART_FINAL)))
        else $error("z update before the cross product was rounded");

    a_part_range: assert property (@(posedge clk) disable iff (!rst_n)
        part_reg <= mbrot_pkg::PART_FINAL)
        else $error("partial product step out of range");
`endif

endmodule
